### hw/rtl/tea_pkg.sv
// Shared types and constants for the TEA block engine.
// No dependencies; imported by tea_block_cipher.
package tea_pkg;

  localparam int unsigned MaxRoundsDef = 64;
  localparam int unsigned RoundW       = 7;
  localparam int unsigned WordW        = 32;
  localparam int unsigned AddrW        = 5;
  localparam int unsigned DataW        = 32;

  localparam logic [WordW-1:0] Delta = 32'h9e37_79b9;
  localparam logic [RoundW-1:0] RoundCountRst = 7'd32;

  localparam logic CmdEncrypt = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  typedef enum logic [2:0] {
    RegKey0   = 3'd0,
    RegKey1   = 3'd1,
    RegKey2   = 3'd2,
    RegKey3   = 3'd3,
    RegRounds = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic             cmd;
    logic [WordW-1:0] block_first;
    logic [WordW-1:0] block_second;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] out_first;
    logic [WordW-1:0] out_second;
  } out_t;

  // Per-stage pipeline payload: words, running sum, cycles still to apply.
  typedef struct packed {
    logic              cmd;
    logic [WordW-1:0]  a;
    logic [WordW-1:0]  b;
    logic [WordW-1:0]  sum;
    logic [RoundW-1:0] rem;
  } stg_t;

endpackage

### hw/rtl/tea_block_cipher.sv
// TEA block engine top level: APB register file and unrolled round pipeline.
// Depends on tea_pkg for payload structs, stage struct and constants.

// Encrypts or decrypts one 64-bit block per beat with TEA, key and round count
// set over APB (key words at 0x0..0xC, round count at 0x10, reset 32; counts
// above MAX_ROUNDS saturate, 0 passes the block through). A new block is taken
// every cycle while the output is not stalled. The round pipeline is unrolled,
// and every block passes through every stage whatever the round count: one entry
// stage that forms the starting sum, then one stage per half of each Feistel
// cycle. Stages past the active count carry the block unchanged. Backpressure
// on the output stalls the whole pipeline.
module tea_block_cipher
  import tea_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = MaxRoundsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam int unsigned NStg = 2 * MAX_ROUNDS + 1;
  localparam int unsigned Last = NStg - 1;

  function automatic logic [WordW-1:0] mix(input logic [WordW-1:0] w,
                                           input logic [WordW-1:0] s,
                                           input logic [WordW-1:0] ka,
                                           input logic [WordW-1:0] kb);
    return ((w << 4) + ka) ^ (w + s) ^ ((w >> 5) + kb);
  endfunction

  // Register file
  logic [WordW-1:0]  key0_q, key1_q, key2_q, key3_q;
  logic [RoundW-1:0] rounds_q;
  reg_idx_e          reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q   <= '0;
      key1_q   <= '0;
      key2_q   <= '0;
      key3_q   <= '0;
      rounds_q <= RoundCountRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegKey0:   key0_q   <= pwdata;
        RegKey1:   key1_q   <= pwdata;
        RegKey2:   key2_q   <= pwdata;
        RegKey3:   key3_q   <= pwdata;
        RegRounds: rounds_q <= pwdata[RoundW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegKey0:   prdata = key0_q;
      RegKey1:   prdata = key1_q;
      RegKey2:   prdata = key2_q;
      RegKey3:   prdata = key3_q;
      RegRounds: prdata = DataW'(rounds_q);
      default:   prdata = '0;
    endcase
  end

  // Pipeline
  logic              adv;
  logic              vld_q [NStg];
  stg_t              stg_q [NStg];
  stg_t              stg_d [NStg];
  logic [RoundW-1:0] n_eff;

  assign adv        = !vld_q[Last] || out_ready_i;
  assign in_ready_o = adv;

  assign n_eff = ({1'b0, rounds_q} > 8'(MAX_ROUNDS)) ? RoundW'(MAX_ROUNDS) : rounds_q;

  always_comb begin
    stg_d[0].cmd = in_data_i.cmd;
    stg_d[0].a   = in_data_i.block_first;
    stg_d[0].b   = in_data_i.block_second;
    stg_d[0].rem = n_eff;
    stg_d[0].sum = (in_data_i.cmd == CmdDecrypt) ? WordW'(Delta * WordW'(n_eff)) : Delta;
  end

  for (genvar j = 1; j < NStg; j++) begin : g_stg
    if ((j % 2) == 1) begin : g_first
      always_comb begin
        stg_d[j] = stg_q[j-1];
        if (stg_q[j-1].rem != '0) begin
          if (stg_q[j-1].cmd == CmdDecrypt) begin
            stg_d[j].b = stg_q[j-1].b
                       - mix(stg_q[j-1].a, stg_q[j-1].sum, key2_q, key3_q);
          end else begin
            stg_d[j].a = stg_q[j-1].a
                       + mix(stg_q[j-1].b, stg_q[j-1].sum, key0_q, key1_q);
          end
        end
      end
    end else begin : g_second
      always_comb begin
        stg_d[j] = stg_q[j-1];
        if (stg_q[j-1].rem != '0) begin
          stg_d[j].rem = stg_q[j-1].rem - 1'b1;
          if (stg_q[j-1].cmd == CmdDecrypt) begin
            stg_d[j].a   = stg_q[j-1].a
                         - mix(stg_q[j-1].b, stg_q[j-1].sum, key0_q, key1_q);
            stg_d[j].sum = stg_q[j-1].sum - Delta;
          end else begin
            stg_d[j].b   = stg_q[j-1].b
                         + mix(stg_q[j-1].a, stg_q[j-1].sum, key2_q, key3_q);
            stg_d[j].sum = stg_q[j-1].sum + Delta;
          end
        end
      end
    end
  end

  for (genvar j = 0; j < NStg; j++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (adv) begin
        vld_q[j] <= (j == 0) ? in_valid_i : vld_q[(j == 0) ? 0 : j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        stg_q[j] <= stg_d[j];
      end
    end
  end

  assign out_valid_o           = vld_q[Last];
  assign out_data_o.out_first  = stg_q[Last].a;
  assign out_data_o.out_second = stg_q[Last].b;

  // Checks
  a_rounds_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> stg_q[Last].rem == '0)
    else $error("output beat with cycles left");

  a_dec_sum_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stg_q[Last].cmd == CmdDecrypt) |-> stg_q[Last].sum == '0)
    else $error("decrypt sum did not unwind to zero");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, n_eff} <= 8'(MAX_ROUNDS)) && (n_eff <= rounds_q))
    else $error("effective round count out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv && vld_q[0]) |=> (vld_q[0] && $stable(stg_q[0])))
    else $error("entry stage changed during stall");

endmodule

### tb/tb_tea_block_cipher.sv
// Self-checking testbench for tea_block_cipher: random valid/ready traffic plus APB setup.
// Depends on tea_pkg (payload structs, register indexes, delta) and the tea_block_cipher RTL.
`timescale 1ns / 1ps

module tb_tea_block_cipher;
  import tea_pkg::*;

  localparam int unsigned Latency  = 2 * MaxRoundsDef + 1;
  localparam int unsigned IdleMax  = 4000;
  localparam int unsigned NumRegs  = (1 << AddrW) / 4;
  localparam int unsigned Phases   = 9;
  localparam int unsigned PerPhase = 50;

  typedef logic [WordW-1:0] word_t;

  class cipher_ledger;
    word_t             key[4];
    logic [RoundW-1:0] rounds;
    out_t              cipher_q[$];
    int unsigned       errors;

    function new();
      foreach (key[i]) key[i] = '0;
      rounds = RoundCountRst;
      errors = 0;
    endfunction

    function void set_reg(int unsigned idx, word_t v);
      case (idx)
        RegKey0:   key[0] = v;
        RegKey1:   key[1] = v;
        RegKey2:   key[2] = v;
        RegKey3:   key[3] = v;
        RegRounds: rounds = v[RoundW-1:0];
        default: ;
      endcase
    endfunction

    function word_t mix(word_t w, word_t s, word_t ka, word_t kb);
      word_t sh_l;
      word_t sh_r;
      sh_l = (w << 4) + ka;
      sh_r = (w >> 5) + kb;
      return sh_l ^ (w + s) ^ sh_r;
    endfunction

    function out_t transform(in_t d);
      word_t       a;
      word_t       b;
      word_t       s;
      int unsigned n;
      out_t        r;
      a = d.block_first;
      b = d.block_second;
      n = (rounds > MaxRoundsDef) ? MaxRoundsDef : rounds;
      if (d.cmd == CmdEncrypt) begin
        s = '0;
        for (int unsigned c = 0; c < n; c++) begin
          s = s + Delta;
          a = a + mix(b, s, key[0], key[1]);
          b = b + mix(a, s, key[2], key[3]);
        end
      end else begin
        s = Delta * word_t'(n);
        for (int unsigned c = 0; c < n; c++) begin
          b = b - mix(a, s, key[2], key[3]);
          a = a - mix(b, s, key[0], key[1]);
          s = s - Delta;
        end
      end
      r.out_first  = a;
      r.out_second = b;
      return r;
    endfunction

    function void note_block(in_t d);
      cipher_q.push_back(transform(d));
    endfunction

    function void check_block(out_t got);
      out_t want;
      if (cipher_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, actual %h", $time, got);
        return;
      end
      want = cipher_q.pop_front();
      if (got.out_first !== want.out_first) begin
        errors++;
        $display("%0t: out_first expected %h actual %h", $time, want.out_first,
                 got.out_first);
      end
      if (got.out_second !== want.out_second) begin
        errors++;
        $display("%0t: out_second expected %h actual %h", $time, want.out_second,
                 got.out_second);
      end
    endfunction

    function int unsigned pending();
      return cipher_q.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  in_t              in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_t             out_data_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  cipher_ledger ledger;
  int unsigned  idle_cycles;

  tea_block_cipher dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(int unsigned idx, word_t v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(4 * idx);
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    ledger.set_reg(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_block(logic cmd, word_t a, word_t b, int unsigned gap);
    in_t d;
    d.cmd          = cmd;
    d.block_first  = a;
    d.block_second = b;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    ledger.note_block(d);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_key(word_t k0, word_t k1, word_t k2, word_t k3);
    write_reg(RegKey0, k0);
    write_reg(RegKey1, k1);
    write_reg(RegKey2, k2);
    write_reg(RegKey3, k3);
  endtask

  task automatic send_both(word_t a, word_t b);
    send_block(CmdEncrypt, a, b, pick_gap());
    send_block(CmdDecrypt, a, b, pick_gap());
  endtask

  // output side: random stalls, occasionally long ready stretches
  initial begin
    int unsigned run;
    int unsigned stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      out_ready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) ledger.check_block(out_data_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleMax) begin
      $display("tea_block_cipher: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    word_t edge_w[5][2];
    int unsigned rc;
    ledger      = new();
    idle_cycles = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: zero key, 32 rounds
    edge_w = '{'{32'h0, 32'h0}, '{32'hffff_ffff, 32'hffff_ffff}, '{32'h0, 32'hffff_ffff},
               '{32'hffff_ffff, 32'h0}, '{32'h0123_4567, 32'h89ab_cdef}};
    foreach (edge_w[i]) send_both(edge_w[i][0], edge_w[i][1]);

    // zero rounds pass the block through
    wait_drained();
    set_key(32'h0011_2233, 32'h4455_6677, 32'h8899_aabb, 32'hccdd_eeff);
    write_reg(RegRounds, 0);
    send_both(32'hdead_beef, 32'hcafe_f00d);

    wait_drained();
    write_reg(RegRounds, 1);
    send_both(32'h1357_9bdf, 32'h2468_ace0);

    wait_drained();
    set_key('1, '1, '1, '1);
    write_reg(RegRounds, MaxRoundsDef);
    send_both(32'hffff_ffff, 32'h0);

    // counts past the maximum saturate
    wait_drained();
    write_reg(RegRounds, MaxRoundsDef + 1);
    send_both(32'h0f0f_0f0f, 32'hf0f0_f0f0);

    wait_drained();
    write_reg(RegRounds, (1 << RoundW) - 1);
    send_both(32'h8000_0000, 32'h0000_0001);

    // writes to unused addresses leave the config alone
    wait_drained();
    for (int unsigned i = int'(RegRounds) + 1; i < NumRegs; i++) write_reg(i, $urandom);
    send_both(32'h7654_3210, 32'hfedc_ba98);

    for (int unsigned p = 0; p < Phases; p++) begin
      wait_drained();
      set_key(rand_word(), rand_word(), rand_word(), rand_word());
      case ($urandom_range(0, 5))
        0: rc = 0;
        1: rc = MaxRoundsDef;
        2: rc = $urandom_range(MaxRoundsDef + 1, (1 << RoundW) - 1);
        3: rc = 1;
        default: rc = $urandom_range(2, MaxRoundsDef - 1);
      endcase
      write_reg(RegRounds, rc);
      for (int unsigned k = 0; k < PerPhase; k++) begin
        send_block(CmdEncrypt ^ logic'($urandom_range(0, 1)), rand_word(), rand_word(),
                   (k < 16) ? 0 : pick_gap());
      end
    end

    wait_drained();
    repeat (Latency + 10) @(posedge clk_i);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("tea_block_cipher: match");
    end else begin
      $display("tea_block_cipher: mismatch");
    end
    $finish;
  end

endmodule
